// File: hw/rtl/pls_pkg.sv
// pls_pkg: shared types and constants for the positional list store.
// Request and status codes, cell command struct and control state type.
// No dependencies.
package pls_pkg;

  // Default list capacity
  localparam int unsigned DEPTH_DEF = 16;

  // Fixed payload widths
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_INS_FIRST = 3'd0,
    REQ_INS_LAST  = 3'd1,
    REQ_DEL_FIRST = 3'd2,
    REQ_DEL_LAST  = 3'd3,
    REQ_INS_AT    = 3'd4,
    REQ_DEL_AT    = 3'd5,
    REQ_REVERSE   = 3'd6,
    REQ_DUMP      = 3'd7
  } req_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_BADPOS = 2'd3
  } status_e;

  // What every cell does in a cycle
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2
  } cell_op_e;

  // Broadcast to the row of cells
  typedef struct packed {
    cell_op_e          op;
    logic [VAL_W-1:0]  value;
  } cell_cmd_t;

  // Control sequencer state
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_e;

endpackage

// File: hw/rtl/pls_cell.sv
// pls_cell: one storage cell of the list row.
// Holds one entry; takes its left or right neighbour's entry or a new value.
// Depends on pls_pkg.
module pls_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned IDX_W = 4
) (
  input  logic                      clk_i,
  input  pls_pkg::cell_cmd_t        cmd_i,
  input  logic [IDX_W-1:0]          slot_i,
  input  logic [pls_pkg::VAL_W-1:0] left_i,
  input  logic [pls_pkg::VAL_W-1:0] right_i,
  output logic [pls_pkg::VAL_W-1:0] value_o
);

  logic [pls_pkg::VAL_W-1:0] value_q;
  logic [pls_pkg::VAL_W-1:0] value_d;
  logic                      at_slot;
  logic                      above_slot;

  assign at_slot    = (slot_i == IDX_W'(IDX));
  assign above_slot = (IDX_W'(IDX) > slot_i);

  // Insert opens a gap at the slot, delete closes it
  always_comb begin
    value_d = value_q;
    unique case (cmd_i.op)
      pls_pkg::OP_INS: begin
        if (at_slot) begin
          value_d = cmd_i.value;
        end else if (above_slot) begin
          value_d = left_i;
        end
      end
      pls_pkg::OP_DEL: begin
        if (at_slot || above_slot) begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  // Entry storage, undefined until written
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// File: hw/rtl/positional_list_store.sv
// positional_list_store: bounded ordered list held in a row of shifting cells.
// Every request other than dump gives one result, in the cycle after it is accepted.
// Dump with N entries, N above zero, gives N results, one per cycle unless the output stalls.
// Reverse flips an orientation flag; no entry moves.
// Reset clears the entry count, orientation and output valid; entries are not cleared.
// Depends on pls_pkg and pls_cell.
module positional_list_store #(
  parameter int unsigned DEPTH = pls_pkg::DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pls_pkg::REQ_W-1:0]     req_type_i,
  input  logic [pls_pkg::POS_W-1:0]     position_i,
  input  logic signed [pls_pkg::VAL_W-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pls_pkg::STATUS_W-1:0]  status_o,
  output logic signed [pls_pkg::VAL_W-1:0] value_out_o,
  output logic [pls_pkg::COUNT_W-1:0]   count_o,
  output logic                          last_o
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned EXT_W =
    ((pls_pkg::POS_W > CNT_W) ? pls_pkg::POS_W : CNT_W) + 1;

  // Control state
  pls_pkg::state_e       state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  rev_q, rev_d;
  logic [CNT_W-1:0]      dump_k_q, dump_k_d;

  // Output register
  logic                          out_valid_q, out_valid_d;
  logic [pls_pkg::STATUS_W-1:0]  out_status_q, out_status_d;
  logic [pls_pkg::VAL_W-1:0]     out_value_q, out_value_d;
  logic [pls_pkg::COUNT_W-1:0]   out_count_q, out_count_d;
  logic                          out_last_q, out_last_d;

  // Decode
  pls_pkg::req_e         req;
  pls_pkg::status_e      dec_status;
  pls_pkg::cell_op_e     dec_op;
  logic                  dec_dump;
  logic                  dec_rev;
  logic [EXT_W-1:0]      cnt_x, pos_x, slot_l, slot_p;
  logic                  full, empty;

  logic                  out_free;
  logic                  in_xfer;
  logic                  dump_last;
  logic [CNT_W-1:0]      dump_phys;

  pls_pkg::cell_cmd_t    cmd;
  logic [IDX_W-1:0]      cell_slot;
  logic [pls_pkg::VAL_W-1:0] cell_val [DEPTH];

  assign req   = pls_pkg::req_e'(req_type_i);
  assign cnt_x = EXT_W'(count_q);
  assign pos_x = EXT_W'(position_i);
  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != pls_pkg::ST_IDLE) || !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Request decode: status, logical slot, cell operation
  always_comb begin
    dec_status = pls_pkg::STAT_OK;
    dec_op     = pls_pkg::OP_HOLD;
    dec_dump   = 1'b0;
    dec_rev    = 1'b0;
    slot_l     = '0;
    unique case (req)
      pls_pkg::REQ_INS_FIRST: begin
        dec_op = pls_pkg::OP_INS;
        slot_l = '0;
        if (full) dec_status = pls_pkg::STAT_FULL;
      end
      pls_pkg::REQ_INS_LAST: begin
        dec_op = pls_pkg::OP_INS;
        slot_l = cnt_x;
        if (full) dec_status = pls_pkg::STAT_FULL;
      end
      pls_pkg::REQ_INS_AT: begin
        dec_op = pls_pkg::OP_INS;
        slot_l = ((pos_x - 1'b1) > cnt_x) ? cnt_x : (pos_x - 1'b1);
        if (position_i == '0) begin
          dec_status = pls_pkg::STAT_BADPOS;
        end else if (full) begin
          dec_status = pls_pkg::STAT_FULL;
        end
      end
      pls_pkg::REQ_DEL_FIRST: begin
        dec_op = pls_pkg::OP_DEL;
        slot_l = '0;
        if (empty) dec_status = pls_pkg::STAT_EMPTY;
      end
      pls_pkg::REQ_DEL_LAST: begin
        dec_op = pls_pkg::OP_DEL;
        slot_l = cnt_x - 1'b1;
        if (empty) dec_status = pls_pkg::STAT_EMPTY;
      end
      pls_pkg::REQ_DEL_AT: begin
        dec_op = pls_pkg::OP_DEL;
        slot_l = ((pos_x - 1'b1) >= cnt_x) ? (cnt_x - 1'b1) : (pos_x - 1'b1);
        if (empty) begin
          dec_status = pls_pkg::STAT_EMPTY;
        end else if (position_i == '0) begin
          dec_status = pls_pkg::STAT_BADPOS;
        end
      end
      pls_pkg::REQ_REVERSE: begin
        dec_rev = 1'b1;
      end
      pls_pkg::REQ_DUMP: begin
        if (empty) begin
          dec_status = pls_pkg::STAT_EMPTY;
        end else begin
          dec_dump = 1'b1;
        end
      end
      default: dec_op = pls_pkg::OP_HOLD;
    endcase
    if (dec_status != pls_pkg::STAT_OK) dec_op = pls_pkg::OP_HOLD;
  end

  // Logical slot to physical cell, honouring orientation
  always_comb begin
    slot_p = slot_l;
    if (rev_q) begin
      if (dec_op == pls_pkg::OP_INS) begin
        slot_p = cnt_x - slot_l;
      end else begin
        slot_p = cnt_x - 1'b1 - slot_l;
      end
    end
  end

  assign cell_slot = slot_p[IDX_W-1:0];

  // Dump read index and end detect
  assign dump_phys = rev_q ? (count_q - 1'b1 - dump_k_q) : dump_k_q;
  assign dump_last = (dump_k_q == (count_q - 1'b1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pls_pkg::ST_IDLE: begin
        if (in_xfer && dec_dump) state_d = pls_pkg::ST_DUMP;
      end
      pls_pkg::ST_DUMP: begin
        if (out_free && dump_last) state_d = pls_pkg::ST_IDLE;
      end
      default: state_d = pls_pkg::ST_IDLE;
    endcase
  end

  // Outputs: cell command, count, orientation, result register
  always_comb begin
    cmd.op       = pls_pkg::OP_HOLD;
    cmd.value    = value_i;
    count_d      = count_q;
    rev_d        = rev_q;
    dump_k_d     = dump_k_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;
    unique case (state_q)
      pls_pkg::ST_IDLE: begin
        if (in_xfer) begin
          cmd.op = dec_op;
          if (dec_op == pls_pkg::OP_INS) count_d = count_q + 1'b1;
          if (dec_op == pls_pkg::OP_DEL) count_d = count_q - 1'b1;
          if (dec_rev) rev_d = !rev_q;
          if (dec_dump) begin
            dump_k_d = '0;
          end else begin
            out_valid_d  = 1'b1;
            out_status_d = dec_status;
            out_value_d  = '0;
            out_count_d  = pls_pkg::COUNT_W'(count_d);
            out_last_d   = 1'b1;
          end
        end
      end
      pls_pkg::ST_DUMP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = pls_pkg::STAT_OK;
          out_value_d  = cell_val[dump_phys[IDX_W-1:0]];
          out_count_d  = pls_pkg::COUNT_W'(count_q);
          out_last_d   = dump_last;
          dump_k_d     = dump_k_q + 1'b1;
        end
      end
      default: cmd.op = pls_pkg::OP_HOLD;
    endcase
  end

  // Row of cells, each wired to its neighbours
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [pls_pkg::VAL_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = cell_val[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = cell_val[g+1];
    end
    pls_cell #(
      .IDX   (g),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .slot_i  (cell_slot),
      .left_i  (left_w),
      .right_i (right_w),
      .value_o (cell_val[g])
    );
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pls_pkg::ST_IDLE;
      count_q     <= '0;
      rev_q       <= 1'b0;
      dump_k_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rev_q       <= rev_d;
      dump_k_q    <= dump_k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_count_q  <= out_count_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign value_out_o = out_value_q;
  assign count_o     = out_count_q;
  assign last_o      = out_last_q;

  // Entry count never exceeds capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // Count only moves on an accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(in_xfer))
    else $error("entry count changed without a request");

  // A non-final result only comes from a dump, with status ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> (out_status_q == pls_pkg::STAT_OK))
    else $error("non-final result with bad status");

  // Dump index stays inside the list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pls_pkg::ST_DUMP) |-> (dump_k_q < count_q))
    else $error("dump index past the end");

endmodule
